// ----- hw/rtl/cfsd_pkg.sv -----
package cfsd_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 16;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_HEADER  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_HEADER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLOSING_MARK  = 2'd2;

    localparam logic [7:0] FIRST_HEADER_RESET  = 8'd170;
    localparam logic [7:0] SECOND_HEADER_RESET = 8'd85;
    localparam logic [7:0] CLOSING_MARK_RESET  = 8'd13;

    // input action codes
    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    typedef enum logic [2:0] {
        PH_HUNT1 = 3'b001,
        PH_HUNT2 = 3'b010,
        PH_BODY  = 3'b100
    } phase_t;

    typedef struct packed {
        logic [7:0] first_header;
        logic [7:0] second_header;
        logic [7:0] closing_mark;
    } cfg_t;

    typedef struct packed {
        logic [15:0] id;
        logic [7:0]  length;
        logic [63:0] data;
    } frame_t;

    localparam int FRAME_W = $bits(frame_t);

    // parser outcome of the current byte, counters already updated
    typedef struct packed {
        logic        push;
        frame_t      frame;
        logic [15:0] trashed;
        logic [15:0] failed;
    } step_t;

endpackage

// ----- hw/rtl/can_frame_serial_deframer.sv -----
// Serial frame deframer with a frame queue. Every accepted item (a serial byte
// or a pop request) yields exactly one result. One item is accepted per cycle
// when the result side keeps up; a result reaches the output through a pipeline
// stage and an output register, because popped frames come from the queue
// memory's registered read port. Holding two results in flight lets the
// input stay ready while one result waits for m_ready. Frames sit in a single
// memory of QUEUE_DEPTH entries; on a full queue a completed frame replaces
// the oldest one. The queue needs no clearing after reset.
module can_frame_serial_deframer
    import cfsd_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH,
    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_wdata,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_action,
    input  logic [7:0]           s_rx_byte,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_frame_valid,
    output logic [15:0]          m_frame_id,
    output logic [7:0]           m_frame_length,
    output logic [63:0]          m_frame_data,
    output logic [CNT_W-1:0]     m_frames_waiting,
    output logic [15:0]          m_trashed_count,
    output logic [15:0]          m_failed_count
);

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.first_header  <= FIRST_HEADER_RESET;
            cfg_reg.second_header <= SECOND_HEADER_RESET;
            cfg_reg.closing_mark  <= CLOSING_MARK_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_FIRST_HEADER:  cfg_reg.first_header  <= cfg_wdata;
                REG_SECOND_HEADER: cfg_reg.second_header <= cfg_wdata;
                REG_CLOSING_MARK:  cfg_reg.closing_mark  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic  s_xfer;
    logic  byte_en;
    logic  pop_hit;
    step_t step;

    assign s_xfer  = s_valid && s_ready;
    assign byte_en = s_xfer && (s_action == ACT_BYTE);

    cfsd_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .byte_en (byte_en),
        .rx_byte (s_rx_byte),
        .cfg     (cfg_reg),
        .step    (step)
    );

    // queue pointers and fill count
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign pop_hit = s_xfer && (s_action == ACT_POP) && (count_reg != '0);

    always_comb begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        count_next  = count_reg;
        if (step.push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (count_reg == CNT_FULL) begin
                // drop the oldest frame
                rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            end else begin
                count_next = count_reg + CNT_W'(1);
            end
        end else if (pop_hit) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            count_next  = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    frame_t ram_rdata;

    cfsd_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue_ram (
        .aclk    (aclk),
        .wr_en   (step.push),
        .wr_addr (wr_ptr_reg),
        .wr_data (step.frame),
        .rd_en   (pop_hit),
        .rd_addr (rd_ptr_reg),
        .rd_data (ram_rdata)
    );

    // stage 1: status of the step, waiting for the memory read data
    logic             p1_valid_reg;
    logic             p1_hit_reg;
    logic [CNT_W-1:0] p1_count_reg;
    logic [15:0]      p1_trashed_reg;
    logic [15:0]      p1_failed_reg;

    // output register
    logic             out_valid_reg;
    logic             out_hit_reg;
    frame_t           out_frame_reg;
    logic [CNT_W-1:0] out_count_reg;
    logic [15:0]      out_trashed_reg;
    logic [15:0]      out_failed_reg;

    logic p1_go;

    assign p1_go   = p1_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !p1_valid_reg || p1_go;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (s_xfer) begin
            p1_valid_reg <= 1'b1;
        end else if (p1_go) begin
            p1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            p1_hit_reg     <= pop_hit;
            p1_count_reg   <= count_next;
            p1_trashed_reg <= step.trashed;
            p1_failed_reg  <= step.failed;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (p1_go) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // the memory read data holds until the next pop, so it is still valid here
    always_ff @(posedge aclk) begin
        if (p1_go) begin
            out_hit_reg     <= p1_hit_reg;
            out_frame_reg   <= p1_hit_reg ? ram_rdata : '0;
            out_count_reg   <= p1_count_reg;
            out_trashed_reg <= p1_trashed_reg;
            out_failed_reg  <= p1_failed_reg;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_frame_valid    = out_hit_reg;
    assign m_frame_id       = out_frame_reg.id;
    assign m_frame_length   = out_frame_reg.length;
    assign m_frame_data     = out_frame_reg.data;
    assign m_frames_waiting = out_count_reg;
    assign m_trashed_count  = out_trashed_reg;
    assign m_failed_count   = out_failed_reg;

    // fill count never exceeds the queue depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_FULL)
        else $error("queue count above depth");

    // a pop on an empty queue returns no frame
    a_empty_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && s_action == ACT_POP && count_reg == '0) |=> !p1_hit_reg)
        else $error("frame returned from empty queue");

    // a push on a full queue keeps the queue full
    a_full_push: assert property (@(posedge aclk) disable iff (!aresetn)
        (step.push && count_reg == CNT_FULL) |=> (count_reg == CNT_FULL))
        else $error("full queue push lost a frame");

    // input stalls only when both result slots are occupied
    a_ready_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (p1_valid_reg && out_valid_reg && !m_ready))
        else $error("input stalled with free result slot");

endmodule

// ----- hw/rtl/cfsd_ram.sv -----
module cfsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    aclk,
    input  logic                                    wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic                                    rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/cfsd_parser.sv -----
module cfsd_parser
    import cfsd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       byte_en,
    input  logic [7:0] rx_byte,
    input  cfg_t       cfg,
    output step_t      step
);

    localparam logic [3:0] POS_LEN   = 4'd2;
    localparam logic [3:0] POS_CLOSE = 4'd11;
    localparam logic [3:0] POS_DATA0 = 4'd3;

    phase_t      phase_reg, phase_next;
    logic [3:0]  pos_reg, pos_next;
    logic [15:0] id_reg, id_next;
    logic [7:0]  len_reg, len_next;
    logic [63:0] data_reg, data_next;
    logic [15:0] trashed_reg, trashed_next;
    logic [15:0] failed_reg, failed_next;
    logic        push;
    logic        fail;
    logic [2:0]  lane;

    assign lane = 3'(pos_reg - POS_DATA0);

    always_comb begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        id_next      = id_reg;
        len_next     = len_reg;
        data_next    = data_reg;
        trashed_next = trashed_reg;
        push         = 1'b0;
        fail         = 1'b0;
        if (byte_en) begin
            unique case (phase_reg)
                PH_HUNT1: begin
                    if (rx_byte == cfg.first_header) begin
                        phase_next = PH_HUNT2;
                    end else begin
                        trashed_next = trashed_reg + 16'd1;
                        fail         = 1'b1;
                    end
                end
                PH_HUNT2: begin
                    if (rx_byte == cfg.second_header) begin
                        phase_next = PH_BODY;
                        pos_next   = '0;
                        id_next    = '0;
                        data_next  = '0;
                    end else begin
                        // the missed byte is not retried as a first header
                        trashed_next = trashed_reg + 16'd2;
                        fail         = 1'b1;
                    end
                end
                PH_BODY: begin
                    if (pos_reg < POS_LEN) begin
                        id_next[{pos_reg[0], 3'b000} +: 8] = rx_byte;
                        pos_next = pos_reg + 4'd1;
                    end else if (pos_reg == POS_LEN) begin
                        len_next = rx_byte;
                        pos_next = pos_reg + 4'd1;
                    end else if (pos_reg < POS_CLOSE) begin
                        data_next[{lane, 3'b000} +: 8] = rx_byte;
                        pos_next = pos_reg + 4'd1;
                    end else if (rx_byte == cfg.closing_mark) begin
                        push       = 1'b1;
                        phase_next = PH_HUNT1;
                        pos_next   = '0;
                        id_next    = '0;
                        data_next  = '0;
                    end else begin
                        fail = 1'b1;
                    end
                end
                default: begin
                    fail = 1'b1;
                end
            endcase
        end
        failed_next = failed_reg;
        if (fail) begin
            // drop the assembly and start hunting again
            failed_next = failed_reg + 16'd1;
            phase_next  = PH_HUNT1;
            pos_next    = '0;
            id_next     = '0;
            len_next    = '0;
            data_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HUNT1;
            pos_reg     <= '0;
            id_reg      <= '0;
            len_reg     <= '0;
            data_reg    <= '0;
            trashed_reg <= '0;
            failed_reg  <= '0;
        end else begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            id_reg      <= id_next;
            len_reg     <= len_next;
            data_reg    <= data_next;
            trashed_reg <= trashed_next;
            failed_reg  <= failed_next;
        end
    end

    assign step.push         = push;
    assign step.frame.id     = id_reg;
    assign step.frame.length = len_reg;
    assign step.frame.data   = data_reg;
    assign step.trashed      = trashed_next;
    assign step.failed       = failed_next;

endmodule

// ----- sim/tb_can_frame_serial_deframer.sv -----
module tb_can_frame_serial_deframer;
    timeunit 1ns;
    timeprecision 1ps;

    import cfsd_pkg::*;

    localparam int DEPTH = DEFAULT_QUEUE_DEPTH;
    localparam int WAIT_W = $clog2(DEFAULT_QUEUE_DEPTH + 1);
    localparam logic [3:0] POS_LEN = 4'd2;
    localparam logic [3:0] POS_CLOSE = 4'd11;
    localparam int IDLE_PCT = 36;
    localparam int SETTLE_CYCLES = 6;
    localparam int RUN_LIMIT = 1_000_000;

    typedef struct packed {
        logic       act;
        logic [7:0] b;
    } rx_item_t;

    typedef struct packed {
        logic              frame_valid;
        frame_t            frame;
        logic [WAIT_W-1:0] waiting;
        logic [15:0]       trashed;
        logic [15:0]       failed;
    } deframe_out_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [7:0]           cfg_wdata = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic                 s_action = ACT_BYTE;
    logic [7:0]           s_rx_byte = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic                 m_frame_valid;
    logic [15:0]          m_frame_id;
    logic [7:0]           m_frame_length;
    logic [63:0]          m_frame_data;
    logic [WAIT_W-1:0]    m_frames_waiting;
    logic [15:0]          m_trashed_count;
    logic [15:0]          m_failed_count;

    can_frame_serial_deframer dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_action         (s_action),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_frame_valid    (m_frame_valid),
        .m_frame_id       (m_frame_id),
        .m_frame_length   (m_frame_length),
        .m_frame_data     (m_frame_data),
        .m_frames_waiting (m_frames_waiting),
        .m_trashed_count  (m_trashed_count),
        .m_failed_count   (m_failed_count)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // deframer state as the block should hold it
    cfg_t        cfg = '{first_header: FIRST_HEADER_RESET,
                         second_header: SECOND_HEADER_RESET,
                         closing_mark: CLOSING_MARK_RESET};
    phase_t      ph = PH_HUNT1;
    logic [3:0]  pos = '0;
    frame_t      asm_frame = '0;
    frame_t      store [DEPTH];
    int          rd_ptr = 0;
    int          wr_ptr = 0;
    int          held = 0;
    logic [15:0] trashed_total = '0;
    logic [15:0] failed_total = '0;

    rx_item_t     rx_items [$];
    deframe_out_t due_outputs [$];
    rx_item_t     next_item;
    deframe_out_t want;
    logic         s_taken = 1'b0;
    logic         calm = 1'b0;
    int           mismatches = 0;
    int           results_seen = 0;
    int           cycle_count = 0;

    function automatic void abandon_frame();
        failed_total = failed_total + 16'd1;
        asm_frame = '0;
        pos = '0;
        ph = PH_HUNT1;
    endfunction

    function automatic deframe_out_t deframe_step(logic act, logic [7:0] b);
        deframe_out_t o;
        o = '0;
        if (act == ACT_BYTE) begin
            case (ph)
                PH_HUNT1: begin
                    if (b == cfg.first_header) begin
                        ph = PH_HUNT2;
                    end else begin
                        trashed_total = trashed_total + 16'd1;
                        abandon_frame();
                    end
                end
                PH_HUNT2: begin
                    if (b == cfg.second_header) begin
                        ph = PH_BODY;
                        asm_frame.id = '0;
                        asm_frame.data = '0;
                        pos = '0;
                    end else begin
                        trashed_total = trashed_total + 16'd2;
                        abandon_frame();
                    end
                end
                default: begin
                    if (pos < POS_LEN) begin
                        asm_frame.id[8*pos +: 8] = b;
                        pos = pos + 4'd1;
                    end else if (pos == POS_LEN) begin
                        asm_frame.length = b;
                        pos = pos + 4'd1;
                    end else if (pos < POS_CLOSE) begin
                        asm_frame.data[8*(pos - POS_LEN - 1) +: 8] = b;
                        pos = pos + 4'd1;
                    end else if (b == cfg.closing_mark) begin
                        // full queue: drop the oldest frame first
                        if (held == DEPTH) begin
                            rd_ptr = (rd_ptr + 1) % DEPTH;
                            held--;
                        end
                        store[wr_ptr] = asm_frame;
                        wr_ptr = (wr_ptr + 1) % DEPTH;
                        held++;
                        asm_frame.id = '0;
                        asm_frame.data = '0;
                        pos = '0;
                        ph = PH_HUNT1;
                    end else begin
                        abandon_frame();
                    end
                end
            endcase
        end else if (held > 0) begin
            o.frame_valid = 1'b1;
            o.frame = store[rd_ptr];
            rd_ptr = (rd_ptr + 1) % DEPTH;
            held--;
        end
        o.waiting = WAIT_W'(held);
        o.trashed = trashed_total;
        o.failed = failed_total;
        return o;
    endfunction

    task automatic check_field(string name, logic [63:0] exp_val, logic [63:0] got_val);
        if (exp_val !== got_val) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("result %0d %s: expected 0x%0h, got 0x%0h",
                         results_seen, name, exp_val, got_val);
            end
        end
    endtask

    // input side: hold the item until its transfer, then maybe idle
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_valid || s_taken) begin
                if (rx_items.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                    next_item = rx_items.pop_front();
                    s_valid <= 1'b1;
                    s_action <= next_item.act;
                    s_rx_byte <= next_item.b;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge aclk) begin
        s_taken <= s_valid && s_ready;
        if (aresetn && m_valid && m_ready) begin
            if (due_outputs.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result %0d arrived with none outstanding", results_seen);
                end
            end else begin
                want = due_outputs.pop_front();
                check_field("frame_valid", 64'(want.frame_valid), 64'(m_frame_valid));
                check_field("frame_id", 64'(want.frame.id), 64'(m_frame_id));
                check_field("frame_length", 64'(want.frame.length), 64'(m_frame_length));
                check_field("frame_data", want.frame.data, m_frame_data);
                check_field("frames_waiting", 64'(want.waiting), 64'(m_frames_waiting));
                check_field("trashed_count", 64'(want.trashed), 64'(m_trashed_count));
                check_field("failed_count", 64'(want.failed), 64'(m_failed_count));
            end
            results_seen++;
        end
        if (aresetn && s_valid && s_ready) begin
            due_outputs.push_back(deframe_step(s_action, s_rx_byte));
        end
    end

    task automatic queue_item(logic act, logic [7:0] b);
        rx_item_t it;
        it.act = act;
        it.b = b;
        rx_items.push_back(it);
    endtask

    task automatic queue_frame(logic [15:0] id, logic [7:0] len, logic [63:0] data,
                               logic [7:0] close);
        queue_item(ACT_BYTE, cfg.first_header);
        queue_item(ACT_BYTE, cfg.second_header);
        queue_item(ACT_BYTE, id[7:0]);
        queue_item(ACT_BYTE, id[15:8]);
        queue_item(ACT_BYTE, len);
        for (int i = 0; i < 8; i++) begin
            queue_item(ACT_BYTE, data[8*i +: 8]);
        end
        queue_item(ACT_BYTE, close);
    endtask

    // mostly well-formed frames, with pops, noise and broken frames mixed in
    task automatic queue_random(int n, int pop_pct);
        int start;
        int kind;
        logic [63:0] fill;
        start = rx_items.size();
        while (rx_items.size() - start < n) begin
            kind = $urandom_range(99);
            if (kind < pop_pct) begin
                repeat ($urandom_range(1, 4)) queue_item(ACT_POP, 8'($urandom));
            end else if (kind < pop_pct + 10) begin
                repeat ($urandom_range(1, 3)) queue_item(ACT_BYTE, 8'($urandom));
            end else if (kind < pop_pct + 22) begin
                case ($urandom_range(2))
                    0: begin
                        queue_item(ACT_BYTE, cfg.first_header);
                        queue_item(ACT_BYTE, cfg.second_header ^ 8'($urandom_range(1, 255)));
                    end
                    1: queue_frame(16'($urandom), 8'($urandom), {$urandom, $urandom},
                                   cfg.closing_mark ^ 8'($urandom_range(1, 255)));
                    default: begin
                        // cut short: later bytes land in the body
                        queue_item(ACT_BYTE, cfg.first_header);
                        queue_item(ACT_BYTE, cfg.second_header);
                        repeat ($urandom_range(9)) queue_item(ACT_BYTE, 8'($urandom));
                    end
                endcase
            end else if ($urandom_range(7) == 0) begin
                fill = $urandom_range(1) ? '1 : '0;
                queue_frame(fill[15:0], fill[7:0], fill, cfg.closing_mark);
            end else begin
                queue_frame(16'($urandom), 8'($urandom), {$urandom, $urandom},
                            cfg.closing_mark);
            end
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_FIRST_HEADER:  cfg.first_header = val;
            REG_SECOND_HEADER: cfg.second_header = val;
            REG_CLOSING_MARK:  cfg.closing_mark = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_config(logic [7:0] first, logic [7:0] second, logic [7:0] close);
        write_reg(REG_FIRST_HEADER, first);
        write_reg(REG_SECOND_HEADER, second);
        write_reg(REG_CLOSING_MARK, close);
    endtask

    task automatic drain();
        while (rx_items.size() != 0 || s_valid || due_outputs.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        while (cycle_count < RUN_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("tb_can_frame_serial_deframer: errors");
        $finish;
    end

    initial begin
        logic [7:0] hdr;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty pop, both header misses, extreme frame, pop until empty
        queue_item(ACT_POP, 8'hFF);
        queue_item(ACT_BYTE, 8'h00);
        queue_item(ACT_BYTE, cfg.first_header);
        queue_item(ACT_BYTE, cfg.first_header);
        queue_frame(16'hFFFF, 8'hFF, '1, cfg.closing_mark);
        queue_item(ACT_POP, 8'h00);
        queue_item(ACT_POP, 8'h5A);
        drain();

        queue_random(400, 20);
        drain();

        set_config(8'h00, 8'hFF, 8'h00);
        // few pops: the queue fills and overflows
        queue_random(350, 6);
        drain();

        set_config(8'hFF, 8'h00, 8'hFF);
        queue_random(350, 35);
        drain();

        // long run of unframed bytes with no idling
        set_config(8'($urandom), 8'($urandom), 8'($urandom));
        calm = 1'b1;
        repeat (250) queue_item(ACT_BYTE, 8'($urandom));
        drain();
        calm = 1'b0;

        // identical header bytes
        hdr = 8'($urandom);
        set_config(hdr, hdr, 8'($urandom));
        queue_random(250, 20);
        drain();

        if (mismatches == 0) begin
            $display("tb_can_frame_serial_deframer: clean");
        end else begin
            $display("tb_can_frame_serial_deframer: errors");
        end
        $finish;
    end

endmodule

// ----- can_frame_serial_deframer.f -----
hw/rtl/cfsd_pkg.sv
hw/rtl/cfsd_ram.sv
hw/rtl/cfsd_parser.sv
hw/rtl/can_frame_serial_deframer.sv
sim/tb_can_frame_serial_deframer.sv
